// File: rtl/wma_pkg.sv
// shared types and constants for the weighted moving average core
// used by wma_divider, weighted_moving_average_core, wma_checker and the testbench
`default_nettype none

package wma_pkg;

  // fractional bits of the averaged result
  localparam int FRAC_BITS = 8;

  // window length after reset
  localparam int WINDOW_RESET = 8;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_DONE
  } wma_div_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } wma_div_status_t;

endpackage

`default_nettype wire

// File: rtl/wma_cell.sv
// one cell of the sample delay chain
// depends on nothing but its neighbors in the chain
`default_nettype none

module wma_cell #(
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                   clk,
  input  wire logic                   shift,
  input  wire logic                   load,
  input  wire logic [SAMPLE_BITS-1:0] sample_in,
  input  wire logic [SAMPLE_BITS-1:0] upper,
  output logic      [SAMPLE_BITS-1:0] data
);

  // the cell at the window's far end takes the new sample, the rest move down
  always_ff @(posedge clk) begin
    if (shift) begin
      data <= load ? sample_in : upper;
    end
  end

endmodule

`default_nettype wire

// File: rtl/wma_divider.sv
// signed by unsigned restoring divider, one quotient bit per cycle
// quotient truncated toward zero; uses wma_pkg
`default_nettype none

module wma_divider import wma_pkg::*; #(
  parameter int NUM_BITS = 36,
  parameter int DEN_BITS = 12,
  parameter int Q_BITS   = 24
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic signed [NUM_BITS-1:0] numer,
  input  wire logic        [DEN_BITS-1:0] denom,
  input  wire logic                       take,
  output wma_div_status_t                 status,
  output logic             [Q_BITS-1:0]   quotient
);

  localparam int CNT_BITS = $clog2(NUM_BITS + 1);

  wma_div_state_t      state;
  wma_div_state_t      state_next;
  logic [DEN_BITS-1:0] rem;
  logic [NUM_BITS-1:0] quo;
  logic [DEN_BITS-1:0] den;
  logic                neg;
  logic [CNT_BITS-1:0] count;

  logic [DEN_BITS:0]   trial;
  logic                fits;
  logic [NUM_BITS-1:0] mag;
  logic [NUM_BITS-1:0] signed_quo;

  always_comb begin
    trial = {rem, quo[NUM_BITS-1]};
    fits  = trial >= {1'b0, den};
    mag   = numer[NUM_BITS-1] ? (~numer + NUM_BITS'(1)) : numer;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      DIV_IDLE: if (start) state_next = DIV_RUN;
      DIV_RUN:  if (count == CNT_BITS'(1)) state_next = DIV_DONE;
      DIV_DONE: if (take) state_next = DIV_IDLE;
      default:  state_next = DIV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DIV_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == DIV_IDLE && start) begin
      rem   <= '0;
      quo   <= mag;
      den   <= denom;
      neg   <= numer[NUM_BITS-1];
      count <= CNT_BITS'(NUM_BITS);
    end else if (state == DIV_RUN) begin
      rem   <= fits ? DEN_BITS'(trial - {1'b0, den}) : DEN_BITS'(trial);
      quo   <= {quo[NUM_BITS-2:0], fits};
      count <= count - CNT_BITS'(1);
    end
  end

  always_comb begin
    signed_quo  = neg ? (~quo + NUM_BITS'(1)) : quo;
    quotient    = signed_quo[Q_BITS-1:0];
    status.busy = state != DIV_IDLE;
    status.done = state == DIV_DONE;
  end

endmodule

`default_nettype wire

// File: rtl/weighted_moving_average_core.sv
// results: an item that completes a window starts the bit-serial divider, and its
// quotient goes out through the output register; other items give no result
// throughput: one item per cycle while the divider is idle; after an item with a result
// s_tready stays low until the divider's quotient has moved to the output register
// reset: synchronous, clears sums, fill count, divider and output valid flag;
// window length returns to 8, the delay chain is left as it was
`default_nettype none

module weighted_moving_average_core import wma_pkg::*; #(
  parameter int WINDOW_MAX  = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  // configuration: window_length
  input  wire logic                                   cfg_wen,
  input  wire logic [$clog2(WINDOW_MAX+1)-1:0]        cfg_wdata,
  // tdata: sample
  input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]       s_tdata,
  // tuser: start_of_series
  input  wire logic                                   s_tuser,
  input  wire logic                                   s_tvalid,
  output logic                                        s_tready,
  // tdata: average
  output logic [((SAMPLE_BITS+FRAC_BITS+7)/8)*8-1:0]  m_tdata,
  output logic                                        m_tvalid,
  input  wire logic                                   m_tready
);

  localparam int WL_BITS      = $clog2(WINDOW_MAX + 1);
  localparam int DEN_MAX      = WINDOW_MAX * (WINDOW_MAX + 1) / 2;
  localparam int DEN_BITS     = $clog2(DEN_MAX + 1);
  localparam int T_BITS       = SAMPLE_BITS + $clog2(DEN_MAX);
  localparam int S_BITS       = SAMPLE_BITS + $clog2(WINDOW_MAX);
  localparam int AVG_BITS     = SAMPLE_BITS + FRAC_BITS;
  localparam int NUM_BITS     = T_BITS + FRAC_BITS;
  localparam int M_TDATA_BITS = ((AVG_BITS + 7) / 8) * 8;
  localparam int W_RESET      = (WINDOW_RESET > WINDOW_MAX) ? WINDOW_MAX : WINDOW_RESET;

  logic [WL_BITS-1:0]          win;
  logic [WINDOW_MAX-1:0]       tap;
  logic [WL_BITS-1:0]          win_next;
  logic signed [T_BITS-1:0]    wsum;
  logic signed [S_BITS-1:0]    psum;
  logic [WL_BITS-1:0]          fill;
  logic [AVG_BITS-1:0]         avg;

  logic                        in_xfer;
  logic signed [SAMPLE_BITS-1:0] x;
  logic signed [T_BITS-1:0]    wsum_cur;
  logic signed [S_BITS-1:0]    psum_cur;
  logic [WL_BITS-1:0]          fill_cur;
  logic signed [SAMPLE_BITS-1:0] oldest;
  logic signed [WL_BITS+SAMPLE_BITS:0] wx;
  logic signed [T_BITS-1:0]    wsum_next;
  logic signed [S_BITS-1:0]    psum_next;
  logic [WL_BITS-1:0]          fill_next;
  logic                        fire;
  logic [2*WL_BITS-1:0]        den_prod;
  logic [DEN_BITS-1:0]         den;
  logic                        take;
  wma_div_status_t             div_status;
  logic [AVG_BITS-1:0]         div_quo;
  logic [SAMPLE_BITS-1:0]      chain [WINDOW_MAX];

  // clamp the written window length into 1..WINDOW_MAX
  always_comb begin
    priority if (cfg_wdata == '0) begin
      win_next = WL_BITS'(1);
    end else if (cfg_wdata > WL_BITS'(WINDOW_MAX)) begin
      win_next = WL_BITS'(WINDOW_MAX);
    end else begin
      win_next = cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win <= WL_BITS'(W_RESET);
      for (int i = 0; i < WINDOW_MAX; i++) begin
        tap[i] <= (i + 1) == W_RESET;
      end
    end else if (cfg_wen) begin
      win <= win_next;
      for (int i = 0; i < WINDOW_MAX; i++) begin
        tap[i] <= win_next == WL_BITS'(i + 1);
      end
    end
  end

  assign in_xfer = s_tvalid && s_tready;
  assign s_tready = !div_status.busy;
  assign x = $signed(s_tdata[SAMPLE_BITS-1:0]);

  // delay chain: new sample enters at the window's far end, oldest leaves at cell 0
  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    wma_cell #(
      .SAMPLE_BITS(SAMPLE_BITS)
    ) u_cell (
      .clk      (clk),
      .shift    (in_xfer),
      .load     (tap[i]),
      .sample_in(s_tdata[SAMPLE_BITS-1:0]),
      .upper    ((i == WINDOW_MAX - 1) ? s_tdata[SAMPLE_BITS-1:0] : chain[(i + 1) % WINDOW_MAX]),
      .data     (chain[i])
    );
  end

  always_comb begin
    wsum_cur  = s_tuser ? '0 : wsum;
    psum_cur  = s_tuser ? '0 : psum;
    fill_cur  = s_tuser ? '0 : fill;
    oldest    = (fill_cur >= win) ? $signed(chain[0]) : '0;
    wx        = $signed({1'b0, win}) * x;
    wsum_next = wsum_cur - T_BITS'(psum_cur) + T_BITS'(wx);
    psum_next = psum_cur + S_BITS'(x) - S_BITS'(oldest);
    fill_next = (fill_cur < win) ? fill_cur + WL_BITS'(1) : fill_cur;
    fire      = fill_next >= win;
    den_prod  = win * (win + WL_BITS'(1));
    den       = DEN_BITS'(den_prod >> 1);
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_wen) begin
      wsum <= '0;
      psum <= '0;
      fill <= '0;
    end else if (in_xfer) begin
      wsum <= wsum_next;
      psum <= psum_next;
      fill <= fill_next;
    end
  end

  wma_divider #(
    .NUM_BITS(NUM_BITS),
    .DEN_BITS(DEN_BITS),
    .Q_BITS  (AVG_BITS)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (in_xfer && fire),
    .numer   ({wsum_next, FRAC_BITS'(0)}),
    .denom   (den),
    .take    (take),
    .status  (div_status),
    .quotient(div_quo)
  );

  // output register frees the divider while a result waits
  assign take = div_status.done && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (take) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      avg <= div_quo;
    end
  end

  assign m_tdata = M_TDATA_BITS'(avg);

endmodule

`default_nettype wire

// File: rtl/wma_checker.sv
// port-level checks for weighted_moving_average_core, bound to the top level
// imports wma_pkg
`default_nettype none

module wma_checker import wma_pkg::*; #(
  parameter int M_TDATA_BITS = 24
) (
  input wire logic                    clk,
  input wire logic                    rst,
  input wire logic                    s_tvalid,
  input wire logic                    s_tready,
  input wire logic [M_TDATA_BITS-1:0] m_tdata,
  input wire logic                    m_tvalid,
  input wire logic                    m_tready
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed or dropped while stalled");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // a result needs the full division, so it never shows the cycle after a transfer
  a_no_instant: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> !$past(s_tvalid && s_tready))
    else $error("result appeared too soon after an input transfer");

endmodule

bind weighted_moving_average_core wma_checker #(
  .M_TDATA_BITS(M_TDATA_BITS)
) u_wma_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .m_tdata (m_tdata),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready)
);

`default_nettype wire

// File: tb/wma_checker.sv
// scoreboard for weighted_moving_average_core: watches the config port and both streams,
// keeps its own window state and compares every average on the master side
// depends on wma_pkg
module wma_scoreboard import wma_pkg::*; #(
  parameter int WINDOW_MAX  = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   cfg_wen,
  input  wire logic [$clog2(WINDOW_MAX+1)-1:0]        cfg_wdata,
  // tdata: sample
  input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]       s_tdata,
  // tuser: start_of_series
  input  wire logic                                   s_tuser,
  input  wire logic                                   s_tvalid,
  input  wire logic                                   s_tready,
  // tdata: average
  input  wire logic [((SAMPLE_BITS+FRAC_BITS+7)/8)*8-1:0]  m_tdata,
  input  wire logic                                   m_tvalid,
  input  wire logic                                   m_tready,
  output int                                          errors,
  output int                                          pending,
  output int                                          checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CFG_W = $clog2(WINDOW_MAX + 1);
  localparam int AVG_W = ((SAMPLE_BITS + FRAC_BITS + 7) / 8) * 8;

  logic [CFG_W-1:0]              window_len;
  longint                        plain_sum;
  longint                        wtd_total;
  int unsigned                   fill_cnt;
  int unsigned                   wr_ptr;
  logic signed [SAMPLE_BITS-1:0] history [WINDOW_MAX];
  logic [AVG_W-1:0]              averages_due [$];
  logic [AVG_W-1:0]              want;

  initial begin
    errors  = 0;
    pending = 0;
    checked = 0;
  end

  task automatic flag_mismatch(input string what);
    errors++;
    $display("%0t ns: mismatch: %s", $time, what);
  endtask

  task automatic restart_series();
    plain_sum = 0;
    wtd_total = 0;
    fill_cnt  = 0;
  endtask

  // incremental update of both sums, then the Q.8 average once the window is full
  task automatic take_sample(input logic signed [SAMPLE_BITS-1:0] x, input logic restart);
    int unsigned w;
    longint      oldest;
    longint      denom;
    longint      avg;
    w = (window_len == 0) ? 1 : (window_len > WINDOW_MAX) ? WINDOW_MAX : window_len;
    if (restart) restart_series();
    oldest = 0;
    if (fill_cnt >= w) oldest = history[(wr_ptr + WINDOW_MAX - w) % WINDOW_MAX];
    wtd_total = wtd_total - plain_sum + longint'(w) * longint'(x);
    plain_sum = plain_sum + longint'(x) - oldest;
    history[wr_ptr] = x;
    wr_ptr = (wr_ptr + 1) % WINDOW_MAX;
    if (fill_cnt < w) fill_cnt++;
    if (fill_cnt >= w) begin
      denom = longint'(w) * longint'(w + 1) / 2;
      // signed division truncates toward zero
      avg = (wtd_total * (longint'(1) << FRAC_BITS)) / denom;
      averages_due.push_back(avg[AVG_W-1:0]);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      window_len = CFG_W'(WINDOW_RESET);
      restart_series();
      wr_ptr = 0;
      foreach (history[i]) history[i] = '0;
      averages_due.delete();
    end else begin
      if (cfg_wen) begin
        window_len = cfg_wdata;
        restart_series();
      end
      if (s_tvalid && s_tready) take_sample($signed(s_tdata[SAMPLE_BITS-1:0]), s_tuser);
      if (m_tvalid && m_tready) begin
        if (averages_due.size() == 0) begin
          flag_mismatch($sformatf("average %h with none expected", m_tdata));
        end else begin
          want = averages_due.pop_front();
          checked++;
          if (m_tdata !== want)
            flag_mismatch($sformatf("average %h, expected %h", m_tdata, want));
        end
      end
    end
    pending <= averages_due.size();
  end

endmodule

// File: tb/tb.sv
// top of the weighted moving average testbench: clock, reset, stream stimulus,
// config writes, watchdog and verdict
// depends on wma_pkg, weighted_moving_average_core and wma_scoreboard
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import wma_pkg::*;

  localparam int WINDOW_MAX   = 64;
  localparam int SAMPLE_BITS  = 16;
  localparam int CFG_W        = $clog2(WINDOW_MAX + 1);
  localparam int DATA_W       = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int AVG_W        = ((SAMPLE_BITS + FRAC_BITS + 7) / 8) * 8;
  localparam int RANDOM_ITEMS = 2000;
  localparam int SETTLE       = 40;    // divider latency plus margin
  localparam int TAIL         = 50;
  localparam int HOLD_CYCLES  = 400;
  localparam int IDLE_LIMIT   = 4000;

  localparam logic [SAMPLE_BITS-1:0] S_MAX  = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] S_MIN  = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic [SAMPLE_BITS-1:0] S_NEG1 = '1;
  localparam logic [SAMPLE_BITS-1:0] S_ZERO = '0;
  localparam logic [SAMPLE_BITS-1:0] S_ONE  = SAMPLE_BITS'(1);

  logic              clk = 1'b0;
  logic              rst;
  logic              cfg_wen;
  logic [CFG_W-1:0]  cfg_wdata;
  logic [DATA_W-1:0] s_tdata;
  logic              s_tuser;
  logic              s_tvalid;
  logic              s_tready;
  logic [AVG_W-1:0]  m_tdata;
  logic              m_tvalid;
  logic              m_tready;

  int fail_count;
  int pending;
  int averages_checked;
  int samples_sent = 0;
  int settings = 1;
  bit hold_req = 1'b0;

  always #2 clk = ~clk;

  weighted_moving_average_core #(
    .WINDOW_MAX  (WINDOW_MAX),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tdata   (m_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready)
  );

  wma_scoreboard #(
    .WINDOW_MAX  (WINDOW_MAX),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) checker_i (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tdata   (m_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .errors    (fail_count),
    .pending   (pending),
    .checked   (averages_checked)
  );

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 90);
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: return S_MAX;
      1: return S_MIN;
      2: return SAMPLE_BITS'($urandom_range(0, 16) - 8);
      3: return ($urandom_range(0, 1) == 1) ? S_NEG1 : S_ZERO;
      default: return SAMPLE_BITS'($urandom());
    endcase
  endfunction

  task automatic send_sample(input logic [SAMPLE_BITS-1:0] x, input logic restart,
                             input bit steady);
    int gap;
    s_tvalid <= 1'b1;
    s_tdata  <= x;
    s_tuser  <= restart;
    do @(posedge clk); while (!s_tready);
    samples_sent++;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // only while idle: a sample without a result may still be in flight
  task automatic set_window(input logic [CFG_W-1:0] v);
    drain();
    repeat (SETTLE) @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_wen <= 1'b0;
    settings++;
  endtask

  // receiver: random stalls, long ready stretches, one long hold-off on request
  initial begin : result_sink
    int ready_run;
    int stall;
    m_tready = 1'b0;
    wait (!rst);
    @(posedge clk);
    forever begin
      ready_run = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                              : $urandom_range(1, 12);
      m_tready <= 1'b1;
      repeat (ready_run) @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        stall = pick_gap();
        if (stall > 0) begin
          m_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wen) idle = 0;
      else idle++;
    end
    $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
    $display("tb NOT OK");
    $finish;
  end

  initial begin : stimulus
    int               total;
    int               phase;
    int               n;
    int               weff;
    bit               steady;
    bit               noisy;
    logic             restart;
    logic [CFG_W-1:0] win;

    rst       = 1'b1;
    cfg_wen   = 1'b0;
    cfg_wdata = '0;
    s_tdata   = '0;
    s_tuser   = 1'b0;
    s_tvalid  = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // window of 8 from reset: full-scale positive series, then negative extremes
    send_sample(S_MAX, 1'b1, 1'b0);
    repeat (7) send_sample(S_MAX, 1'b0, 1'b0);
    repeat (2) send_sample(S_MIN, 1'b0, 1'b0);
    // restart in the middle: series not full again
    send_sample(S_NEG1, 1'b1, 1'b0);

    // zero is taken as a window of one
    set_window('0);
    send_sample(S_MIN, 1'b0, 1'b0);
    send_sample(S_MAX, 1'b0, 1'b0);
    send_sample(S_ZERO, 1'b0, 1'b0);
    send_sample(S_NEG1, 1'b0, 1'b0);
    send_sample(S_ONE, 1'b1, 1'b0);

    set_window(CFG_W'(2));
    send_sample(S_MAX, 1'b0, 1'b0);
    send_sample(S_MIN, 1'b0, 1'b0);
    send_sample(S_ONE, 1'b0, 1'b0);
    send_sample(S_MIN, 1'b1, 1'b0);
    send_sample(S_MIN, 1'b0, 1'b0);

    total = 0;
    phase = 0;
    while (total < RANDOM_ITEMS) begin
      case (phase)
        0: win = CFG_W'(WINDOW_MAX);
        1: win = '1;
        2: win = CFG_W'(1);
        3: win = CFG_W'(WINDOW_MAX + 1);
        4: win = '0;
        default: begin
          if ($urandom_range(0, 9) < 7) win = CFG_W'($urandom_range(1, 8));
          else if ($urandom_range(0, 4) == 0) win = CFG_W'($urandom());
          else win = CFG_W'($urandom_range(9, WINDOW_MAX));
        end
      endcase
      weff   = (win == 0) ? 1 : (win > WINDOW_MAX) ? WINDOW_MAX : win;
      n      = weff + $urandom_range(10, 120);
      steady = ($urandom_range(0, 3) == 0);
      noisy  = ($urandom_range(0, 4) == 0);
      set_window(win);
      for (int k = 0; k < n; k++) begin
        // output stalled long enough that the input backs up
        if (phase == 0 && k == weff + 2) hold_req = 1'b1;
        if (phase == 1 && k == n / 2) drain();
        restart = noisy ? ($urandom_range(0, 3) == 0) : ($urandom_range(0, 79) == 0);
        send_sample(pick_sample(), restart, steady);
      end
      total += n;
      phase++;
    end

    drain();
    repeat (TAIL) @(posedge clk);
    $display("covered %0d samples over %0d window settings, %0d averages compared",
             samples_sent, settings, averages_checked);
    $display("mismatches: %0d, averages still outstanding: %0d", fail_count, pending);
    if (fail_count == 0 && pending == 0) $display("tb OK");
    else $display("tb NOT OK");
    $finish;
  end

endmodule
